// ===== design/b64d_pkg.sv =====
// types, constants and symbol mapping shared by the base64 decoder
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [2:0] {
    ST_BYTE          = 3'd0,
    ST_BAD_SYM       = 3'd1,
    ST_AFTER_PAD     = 3'd2,
    ST_MISPLACED_PAD = 3'd3,
    ST_BAD_LEN       = 3'd4
  } status_t;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  pos;
    logic [1:0]  pad;
    logic        swallow;
  } dec_state_t;

  // results caused by one item; cnt of zero means none
  typedef struct packed {
    logic [1:0]  cnt;
    status_t     status;
    logic        eos;
    logic [23:0] bytes;
  } dec_res_t;

  // 6-bit alphabet value, bit 6 set for a byte outside the alphabet
  function automatic logic [6:0] sym_value(input logic [7:0] c);
    logic [6:0] v;
    v = 7'd64;
    if (c inside {[8'h41:8'h5A]}) begin
      v = 7'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

// ===== design/b64d_step.sv =====
// next-state and result logic for one character of the base64 decoder
module b64d_step (
  input  b64d_pkg::dec_state_t st,
  input  logic [7:0]           symbol_char,
  input  logic                 last_symbol,
  output b64d_pkg::dec_state_t st_nxt,
  output b64d_pkg::dec_res_t   res
);
  import b64d_pkg::*;

  logic [6:0]  v;
  logic        is_sym;
  logic        is_pad;
  logic [23:0] shifted;
  logic [1:0]  pad_new;
  logic        err;
  status_t     code;

  always_comb begin
    v       = sym_value(symbol_char);
    is_sym  = !v[6];
    is_pad  = (symbol_char == PAD_CHAR);
    shifted = {st.bits[17:0], (is_sym ? v[5:0] : 6'd0)};
    pad_new = st.pad + {1'b0, is_pad};
    err     = 1'b0;
    code    = ST_BYTE;
    st_nxt  = st;
    res     = '0;
    res.status = ST_BYTE;

    if (st.swallow) begin
      if (last_symbol) begin
        st_nxt = '0;
      end
    end else if (st.pos == 2'd3 && (st.pad != 2'd0 || is_pad) && !last_symbol) begin
      err  = 1'b1;
      code = ST_MISPLACED_PAD;
    end else if (is_sym && st.pad != 2'd0) begin
      err  = 1'b1;
      code = ST_AFTER_PAD;
    end else if (is_pad && st.pos < 2'd2) begin
      err  = 1'b1;
      code = ST_MISPLACED_PAD;
    end else if (!is_sym && !is_pad) begin
      err  = 1'b1;
      code = ST_BAD_SYM;
    end else if (st.pos != 2'd3 && last_symbol) begin
      err  = 1'b1;
      code = ST_BAD_LEN;
    end else if (st.pos != 2'd3) begin
      st_nxt.bits = shifted;
      st_nxt.pos  = st.pos + 2'd1;
      st_nxt.pad  = pad_new;
    end else begin
      // group complete
      res.cnt   = (pad_new >= 2'd2) ? 2'd1 : 2'd3 - pad_new;
      res.bytes = shifted;
      res.eos   = last_symbol;
      st_nxt    = '0;
    end

    if (err) begin
      res.cnt        = 2'd1;
      res.status     = code;
      res.eos        = last_symbol;
      res.bytes      = '0;
      st_nxt         = '0;
      st_nxt.swallow = !last_symbol;
    end
  end

endmodule

// ===== design/base64_decoder_checked.sv =====
// top level of the base64 decoder with error checking
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  symbol_char, last_symbol
//  out_     output     out_valid/out_stall data_byte, status, last_of_run, end_of_stream
//
// one character is taken per cycle unless in_stall is high; a complete group
// gives up to three bytes, sent one per cycle from the result register unless
// out_stall is high
// an accepted character is registered, then its results go to the result register
// rst_n is synchronous and clears all control state and the group
// out_stall holds the result register; in_stall rises only when an item with
// results waits for the result register to free
module base64_decoder_checked (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_symbol_char,
  input  logic       in_last_symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_status,
  output logic       out_last_of_run,
  output logic       out_end_of_stream
);
  import b64d_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] chr_r;
  logic       lst_r;

  dec_state_t st_r, st_nxt, stp_st;
  dec_res_t   stp_res;
  dec_res_t   pk_r;
  logic       pk_vld_r, pk_vld_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic out_fire, pk_last, pk_free, has_res, adv, pk_load;

  b64d_step u_step (
    .st          (st_r),
    .symbol_char (chr_r),
    .last_symbol (lst_r),
    .st_nxt      (stp_st),
    .res         (stp_res)
  );

  always_comb begin
    out_fire   = pk_vld_r && !out_stall;
    pk_last    = (idx_r == pk_r.cnt - 2'd1);
    pk_free    = !pk_vld_r || (out_fire && pk_last);
    has_res    = (stp_res.cnt != 2'd0);
    adv        = in_vld_r && (!has_res || pk_free);
    pk_load    = adv && has_res;
    in_stall   = in_vld_r && !adv;
    in_vld_nxt = in_stall ? in_vld_r : in_valid;
    st_nxt     = adv ? stp_st : st_r;
    pk_vld_nxt = pk_vld_r;
    idx_nxt    = idx_r;
    if (pk_load) begin
      pk_vld_nxt = 1'b1;
      idx_nxt    = 2'd0;
    end else if (out_fire) begin
      if (pk_last) begin
        pk_vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      pk_vld_r <= 1'b0;
      idx_r    <= 2'd0;
      st_r     <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      pk_vld_r <= pk_vld_nxt;
      idx_r    <= idx_nxt;
      st_r     <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      chr_r <= in_symbol_char;
      lst_r <= in_last_symbol;
    end
    if (pk_load) begin
      pk_r <= stp_res;
    end
  end

  always_comb begin
    out_valid = pk_vld_r;
    case (idx_r)
      2'd0:    out_data_byte = pk_r.bytes[23:16];
      2'd1:    out_data_byte = pk_r.bytes[15:8];
      2'd2:    out_data_byte = pk_r.bytes[7:0];
      default: out_data_byte = 8'd0;
    endcase
    out_status        = pk_r.status;
    out_last_of_run   = pk_last;
    out_end_of_stream = pk_last && pk_r.eos;
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pk_vld_r |-> (pk_r.cnt != 2'd0 && idx_r < pk_r.cnt))
    else $error("result index beyond result count");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_BYTE) |-> (out_data_byte == 8'd0 && out_last_of_run))
    else $error("error result not a single zero result");

  a_swallow_clean: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.swallow |-> (st_r.pos == 2'd0 && st_r.pad == 2'd0))
    else $error("group not cleared while swallowing");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> !in_stall)
    else $error("stall with empty input register");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(idx_r)))
    else $error("stalled result moved");

endmodule

// ===== sim/tb_base64_decoder_checked.sv =====
// testbench for base64_decoder_checked: directed and random character streams, scoreboard check
`timescale 1ns / 100ps

module tb_base64_decoder_checked;
  import b64d_pkg::*;

  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 400;

  typedef struct {
    logic [7:0] data;
    status_t    status;
    logic       run_end;
    logic       stream_end;
  } dec_result_t;

  class decode_scoreboard;
    logic [23:0] group;
    logic [1:0]  position;
    logic [1:0]  pads;
    bit          swallowing;
    dec_result_t pending_results[$];
    int unsigned mismatches;

    function new();
      clear_group();
      swallowing = 1'b0;
      mismatches = 0;
    endfunction

    function void clear_group();
      group    = '0;
      position = '0;
      pads     = '0;
    endfunction

    // six-bit value of an alphabet character, bit 6 set when outside the alphabet
    function logic [6:0] char_code(logic [7:0] c);
      logic [6:0] code;
      code = 7'h40;
      if (c >= "A" && c <= "Z") code = 7'(c - "A");
      else if (c >= "a" && c <= "z") code = 7'(c - "a") + 7'd26;
      else if (c >= "0" && c <= "9") code = 7'(c - "0") + 7'd52;
      else if (c == "+") code = 7'd62;
      else if (c == "/") code = 7'd63;
      return code;
    endfunction

    function void push_error(status_t code, logic last);
      pending_results.push_back(dec_result_t'{8'h00, code, 1'b1, last});
      clear_group();
      swallowing = !last;
    endfunction

    // returns 1 when the item was decoded rather than swallowed
    function bit note_char(logic [7:0] c, logic last);
      logic [6:0] code;
      logic       is_pad;
      int         n;
      code   = char_code(c);
      is_pad = (c == PAD_CHAR);
      if (swallowing) begin
        if (last) begin
          clear_group();
          swallowing = 1'b0;
        end
        return 1'b0;
      end
      // padded group that is not the last one
      if (position == 2'd3 && (pads != 2'd0 || is_pad) && !last) begin
        push_error(ST_MISPLACED_PAD, last);
        return 1'b1;
      end
      if (!code[6]) begin
        if (pads != 2'd0) begin
          push_error(ST_AFTER_PAD, last);
          return 1'b1;
        end
        group = {group[17:0], code[5:0]};
      end else if (is_pad) begin
        if (position < 2'd2) begin
          push_error(ST_MISPLACED_PAD, last);
          return 1'b1;
        end
        pads  = pads + 2'd1;
        group = {group[17:0], 6'd0};
      end else begin
        push_error(ST_BAD_SYM, last);
        return 1'b1;
      end
      if (position != 2'd3) begin
        if (last) push_error(ST_BAD_LEN, last);
        else position = position + 2'd1;
        return 1'b1;
      end
      n = 3 - int'(pads);
      if (n < 1) n = 1;
      for (int k = 0; k < n; k++) begin
        pending_results.push_back(dec_result_t'{group[23 - 8*k -: 8], ST_BYTE,
                                                k == n - 1, (k == n - 1) && last});
      end
      clear_group();
      return 1'b1;
    endfunction

    function void check_result(logic [7:0] d, logic [2:0] st, logic lor, logic eos);
      dec_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: data_byte %0h status %0d", d, st);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      if (d !== e.data) begin
        $error("data_byte: expected %0h, actual %0h", e.data, d);
        mismatches++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        mismatches++;
      end
      if (lor !== e.run_end) begin
        $error("last_of_run: expected %0b, actual %0b", e.run_end, lor);
        mismatches++;
      end
      if (eos !== e.stream_end) begin
        $error("end_of_stream: expected %0b, actual %0b", e.stream_end, eos);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_symbol_char = 8'h00;
  logic       in_last_symbol = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic [2:0] out_status;
  logic       out_last_of_run;
  logic       out_end_of_stream;

  decode_scoreboard sb = new();
  int unsigned      decoded_items = 0;
  int unsigned      stuck_cycles = 0;
  bit               no_idle = 1'b0;

  base64_decoder_checked dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_symbol_char    (in_symbol_char),
    .in_last_symbol    (in_last_symbol),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_byte     (out_data_byte),
    .out_status        (out_status),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] alphabet_char();
    int unsigned i;
    i = $urandom_range(0, 63);
    if (i < 26) return 8'("A" + i);
    if (i < 52) return 8'("a" + i - 26);
    if (i < 62) return 8'("0" + i - 52);
    return (i == 62) ? 8'("+") : 8'("/");
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0: return PAD_CHAR;
      1: return alphabet_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_symbol_char <= c;
    in_last_symbol <= last;
    do @(posedge clk); while (in_stall);
    void'(sb.note_char(c, last));
    decoded_items++;
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_char(s[i], close && i == s.len() - 1);
  endtask

  // hold the sender until every pending result has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  task automatic send_wellformed_stream();
    int unsigned groups;
    int unsigned npad;
    int unsigned pad_group;
    int unsigned total;
    int unsigned bad_at;
    bit          corrupt;
    logic [7:0]  ch;
    groups    = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    npad      = $urandom_range(0, 2);
    pad_group = (groups > 1 && $urandom_range(0, 9) == 0) ? 0 : groups - 1;
    total     = groups * 4;
    if ($urandom_range(0, 9) == 0) total = total - $urandom_range(1, 3);
    corrupt = ($urandom_range(0, 5) == 0);
    bad_at  = $urandom_range(0, total - 1);
    for (int i = 0; i < total; i++) begin
      ch = alphabet_char();
      if (i / 4 == pad_group && i % 4 >= 4 - npad) ch = PAD_CHAR;
      if (corrupt && i == bad_at) ch = noise_char();
      send_char(ch, i == total - 1);
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_data_byte, out_status, out_last_of_run, out_end_of_stream);
  end

  // result stall pattern: clear stretches, random stalls and long holds
  initial begin
    int unsigned r;
    repeat (12) @(posedge clk);
    forever begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else if (r < 9) begin
        repeat ($urandom_range(10, 40)) begin
          out_stall <= ($urandom_range(0, 2) == 0);
          @(posedge clk);
        end
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed streams
    send_text("QUI=", 1'b1);
    send_text("QQ==", 1'b1);
    send_text("AZaz09+/", 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_text("QQ=", 1'b1);
    send_text("QQ=A", 1'b1);
    send_text("=", 1'b1);
    drain();

    // random streams, mostly well formed
    while (decoded_items < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        send_wellformed_stream();
      end else begin
        repeat ($urandom_range(1, 10) - 1) send_char(noise_char(), 1'b0);
        send_char(noise_char(), 1'b1);
      end
      if ($urandom_range(0, 24) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
